@@ rtl/drop_and_wheelslip_detector_top_assert.svh @@
`ifndef DROP_AND_WHEELSLIP_DETECTOR_TOP_ASSERT_SVH
`define DROP_AND_WHEELSLIP_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dsw_pkg.sv @@
`default_nettype none

package dsw_pkg;

  // Port widths, padded to whole bytes.
  localparam int IN_W  = 104;
  localparam int OUT_W = 40;

  // Fixed-point constants.
  localparam logic [16:0] Q_ONE_ALPHA     = 17'd65536;
  localparam logic [15:0] Q_ONE_15        = 16'd32768;
  localparam logic [16:0] ACCEL_OFFSET    = 17'd1280;
  localparam logic [15:0] FULL_ACCEL_SPAN = 16'd1280;
  // Reciprocal of five scaled by 2^18; exact for dividends below 2^18.
  localparam logic [15:0] RECIP5          = 16'd52429;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_THR_Z    = 2'd1;
  localparam logic [1:0] REG_THR_N    = 2'd2;
  localparam logic [1:0] REG_STRENGTH = 2'd3;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic        [16:0] alpha;
    logic signed [15:0] thr_z;
    logic        [29:0] thn_sq;
    logic        [15:0] strength;
  } cfg_t;

  // Step strobes from the sequencer to the lanes and the merge stage.
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic sqr;
    logic sum;
  } step_t;

  // One result word.
  typedef struct packed {
    logic [15:0] wheelslip_level;
    logic [15:0] drop_multiplier;
    logic        drop_flag;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/dsw_lane.sv @@
`default_nettype none

module dsw_lane import dsw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire step_t              step,
  input  wire logic        [16:0] alpha,
  input  wire logic signed [15:0] sample,
  output logic signed      [31:0] filt,
  output logic             [63:0] sq
);

  logic signed [15:0] sample_r;
  logic signed [50:0] prod_r;
  logic signed [50:0] prod_nxt;
  logic signed [31:0] filt_r;
  logic signed [31:0] filt_nxt;
  logic        [63:0] sq_r;
  logic        [63:0] sq_nxt;
  logic signed [31:0] s28;
  logic signed [32:0] diff;
  logic signed [17:0] alpha_s;
  logic        [31:0] mag;

  // EMA difference times alpha, then floor by 2^16 and accumulate.
  always_comb begin
    s28      = {sample_r, 16'h0000};
    diff     = {s28[31], s28} - {filt_r[31], filt_r};
    alpha_s  = {1'b0, alpha};
    prod_nxt = diff * alpha_s;
    filt_nxt = filt_r + prod_r[47:16];
    mag      = filt_r[31] ? (32'd0 - filt_r) : filt_r;
    sq_nxt   = mag * mag;
  end

  // Filter state is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (step.upd) begin
      filt_r <= filt_nxt;
    end
  end

  // Working registers of the lane.
  always_ff @(posedge clk) begin
    if (step.load) begin
      sample_r <= sample;
    end
    if (step.mul) begin
      prod_r <= prod_nxt;
    end
    if (step.sqr) begin
      sq_r <= sq_nxt;
    end
  end

  assign filt = filt_r;
  assign sq   = sq_r;

endmodule

`default_nettype wire

@@ rtl/dsw_merge.sv @@
`default_nettype none

module dsw_merge import dsw_pkg::*; (
  input  wire logic               clk,
  input  wire step_t              step,
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] motor_accel,
  input  wire logic        [15:0] speed_magnitude,
  input  wire logic signed [15:0] duty,
  input  wire logic               braking,
  input  wire logic signed [31:0] filt_z,
  input  wire logic        [63:0] sq_x,
  input  wire logic        [63:0] sq_y,
  output res_t                    res
);

  logic signed [15:0] macc_r;
  logic        [15:0] speed_r;
  logic signed [15:0] duty_r;
  logic               braking_r;
  logic        [15:0] af_r;
  logic        [15:0] af_nxt;
  logic        [31:0] afs_r;
  logic        [31:0] afs_nxt;
  logic        [46:0] slp_r;
  logic        [46:0] slp_nxt;
  logic        [15:0] slip_r;
  logic        [15:0] slip_nxt;
  logic        [64:0] mag2_r;
  logic        [64:0] mag2_nxt;
  logic               zc_r;
  logic               zc_nxt;
  logic        [15:0] amag;
  logic        [16:0] excess;
  logic               excess_pos;
  logic               duty_pos;
  logic        [26:0] af_frac;
  logic        [24:0] p_shr;
  logic               drop;

  // Acceleration factor: (excess * 128) / 5, saturated at full span.
  always_comb begin
    amag       = macc_r[15] ? (16'd0 - macc_r) : macc_r;
    excess     = {1'b0, amag} - ACCEL_OFFSET;
    excess_pos = !excess[16] && (excess != 17'd0);
    duty_pos   = !duty_r[15] && (duty_r != 16'sd0);
    af_frac    = excess[10:0] * RECIP5;
    if (!braking_r && duty_pos && excess_pos) begin
      af_nxt = (excess[15:0] >= FULL_ACCEL_SPAN) ? Q_ONE_15 : af_frac[26:11];
    end else begin
      af_nxt = '0;
    end
  end

  // Wheelslip product over two multiplier steps, then shift and clamp.
  always_comb begin
    afs_nxt  = af_r * speed_r;
    slp_nxt  = afs_r * duty_r[14:0];
    p_shr    = slp_r[46:22];
    slip_nxt = (p_shr > {9'd0, Q_ONE_15}) ? Q_ONE_15 : p_shr[15:0];
  end

  // Drop conditions: horizontal magnitude squared and vertical threshold.
  always_comb begin
    mag2_nxt = {1'b0, sq_x} + {1'b0, sq_y};
    zc_nxt   = $signed(filt_z[31:16]) < cfg.thr_z;
    drop     = zc_r && (mag2_r[64:32] < {3'd0, cfg.thn_sq});
    res.drop_flag       = drop;
    res.drop_multiplier = drop ? cfg.strength : Q_ONE_15;
    res.wheelslip_level = slip_r;
  end

  // Step registers of the merge stage.
  always_ff @(posedge clk) begin
    if (step.load) begin
      macc_r    <= motor_accel;
      speed_r   <= speed_magnitude;
      duty_r    <= duty;
      braking_r <= braking;
    end
    if (step.mul) begin
      af_r <= af_nxt;
    end
    if (step.upd) begin
      afs_r <= afs_nxt;
    end
    if (step.sqr) begin
      slp_r <= slp_nxt;
    end
    if (step.sum) begin
      slip_r <= slip_nxt;
      mag2_r <= mag2_nxt;
      zc_r   <= zc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/drop_and_wheelslip_detector_top.sv @@
// An accepted word runs the five-step sequence (load, multiply, update, square,
// sum) of the three filter lanes and the merge stage. A new word is taken only
// while the sequence is idle, and the last step holds while the output is full.
// A finished result waits in the output register while the next word is taken.
// Reset (rst_n low, synchronous) clears the filter state, the sequencer and
// the output valid, and restores the configuration registers to their defaults.
`default_nettype none

module drop_and_wheelslip_detector_top import dsw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // accel_x, accel_y, accel_z, motor_accel, speed_magnitude, duty, braking, pad
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // drop_flag, drop_multiplier, wheelslip_level, pad
  output logic      [OUT_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire logic             cfg_wen,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [16:0]      cfg_wdata
);

  cfg_t               cfg_r;
  cfg_t               cfg_nxt;
  logic [4:0]         phase_r;
  logic [4:0]         phase_nxt;
  logic               out_tvalid_r;
  logic               out_tvalid_nxt;
  res_t               res_r;
  res_t               res;
  step_t              step;
  logic               in_accept;
  logic               hold;
  logic               out_load;
  logic signed [31:0] filt_x;
  logic signed [31:0] filt_y;
  logic signed [31:0] filt_z;
  logic        [63:0] sq_x;
  logic        [63:0] sq_y;
  logic        [63:0] sq_z;

  // Configuration writes, alpha and strength saturated; the n threshold is kept squared.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      case (cfg_index)
        REG_ALPHA: begin
          cfg_nxt.alpha = (cfg_wdata > Q_ONE_ALPHA) ? Q_ONE_ALPHA : cfg_wdata;
        end
        REG_THR_Z: begin
          cfg_nxt.thr_z = cfg_wdata[15:0];
        end
        REG_THR_N: begin
          cfg_nxt.thn_sq = cfg_wdata[14:0] * cfg_wdata[14:0];
        end
        REG_STRENGTH: begin
          cfg_nxt.strength = (cfg_wdata[15:0] > Q_ONE_15) ? Q_ONE_15 : cfg_wdata[15:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // Step sequencer: one-hot phase, held on the last step while output is full.
  always_comb begin
    in_tready      = (phase_r == 5'd0);
    in_accept      = in_tvalid && in_tready;
    hold           = phase_r[4] && out_tvalid_r && !out_tready;
    out_load       = phase_r[4] && !hold;
    phase_nxt      = hold ? phase_r : {phase_r[3:0], in_accept};
    out_tvalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
    step.load      = in_accept;
    step.mul       = phase_r[0];
    step.upd       = phase_r[1];
    step.sqr       = phase_r[2];
    step.sum       = phase_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha    <= Q_ONE_ALPHA;
      cfg_r.thr_z    <= '0;
      cfg_r.thn_sq   <= '0;
      cfg_r.strength <= Q_ONE_15;
      phase_r        <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      phase_r      <= phase_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res;
    end
  end

  // Three filter lanes, one per axis.
  dsw_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .alpha  (cfg_r.alpha),
    .sample (in_tdata[15:0]),
    .filt   (filt_x),
    .sq     (sq_x)
  );

  dsw_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .alpha  (cfg_r.alpha),
    .sample (in_tdata[31:16]),
    .filt   (filt_y),
    .sq     (sq_y)
  );

  dsw_lane u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .alpha  (cfg_r.alpha),
    .sample (in_tdata[47:32]),
    .filt   (filt_z),
    .sq     (sq_z)
  );

  // Merge: drop decision and wheelslip level.
  dsw_merge u_merge (
    .clk             (clk),
    .step            (step),
    .cfg             (cfg_r),
    .motor_accel     (in_tdata[63:48]),
    .speed_magnitude (in_tdata[79:64]),
    .duty            (in_tdata[95:80]),
    .braking         (in_tdata[96]),
    .filt_z          (filt_z),
    .sq_x            (sq_x),
    .sq_y            (sq_y),
    .res             (res)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, res_r.wheelslip_level, res_r.drop_multiplier, res_r.drop_flag};

endmodule

`default_nettype wire

@@ rtl/dsw_checker.sv @@
`default_nettype none

`include "drop_and_wheelslip_detector_top_assert.svh"

module dsw_checker import dsw_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready
);

  // A stalled result word keeps its value.
  `DSW_ASSERT_NEXT(a_out_hold,
    out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata),
    "result word changed while stalled")

  // Without a drop the multiplier is exactly one.
  `DSW_ASSERT_NOW(a_mult_one,
    out_tvalid && !out_tdata[0],
    out_tdata[16:1] == Q_ONE_15,
    "multiplier not one outside a drop")

  // The wheelslip level never exceeds one.
  `DSW_ASSERT_NOW(a_slip_max,
    out_tvalid,
    out_tdata[32:17] <= Q_ONE_15,
    "wheelslip level above one")

  // One word is worked on at a time, so input is closed right after a word.
  `DSW_ASSERT_NEXT(a_busy,
    in_tvalid && in_tready,
    !in_tready,
    "input open while a word is in work")

endmodule

bind drop_and_wheelslip_detector_top dsw_checker u_checker (.*);

`default_nettype wire
